// File: design/ptsp_pkg.sv
package ptsp_pkg;

  localparam int COEF_COUNT = 32;
  localparam int COEF_AW    = 5;
  localparam int NDC_W      = 42;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 8'd3;

  localparam logic ACTION_PROJECT = 1'b0;
  localparam logic ACTION_LOAD    = 1'b1;

  typedef struct packed {
    logic               action;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } cmd_t;

  typedef struct packed {
    logic               projected_ok;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_depth;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/point_to_screen_projection.sv
// channel  direction  handshake            payload
// cmd      in         cmd_valid/cmd_stall  cmd_t: load coefficient or project point
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data: viewport registers
// res      out        res_valid/res_stall  res_t: one transaction per projected point
//
// a coefficient load is written into the store while idle; a point takes
// multiply-accumulate passes on the one shared multiplier plus three
// divisions on the bit-serial divider, one per clip coordinate.
// rst is synchronous; it restores the viewport registers, the coefficient
// store stays undefined until loaded. cmd_stall is high while a point is in
// work; a stalled result holds in the output register.
module point_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  ptsp_pkg::cmd_t                   cmd,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  output logic                             res_valid,
  input  logic                             res_stall,
  output ptsp_pkg::res_t                   res
);
  import ptsp_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [63:0] NDC_MAX = 64'd1 << 40;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_ACC   = 8'b00001000,
    S_DIVGO = 8'b00010000,
    S_DIVW  = 8'b00100000,
    S_MAP   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;

  logic [11:0] view_left, view_top;
  logic [12:0] view_width, view_height;

  logic [31:0] mem [COEF_COUNT];
  logic signed [31:0] rdata;
  logic [COEF_AW-1:0] addr;

  logic               phase;
  logic [1:0]         row, k;
  logic signed [31:0] px, py, pz;
  logic signed [31:0] eye [4];
  logic signed [31:0] clip [3];
  logic signed [NDC_W-1:0] ndc [3];
  logic signed [63:0] acc;
  logic               zero_z;

  logic signed [31:0] mul_b;
  logic signed [63:0] term, acc_next;
  logic signed [31:0] acc_sat;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [NDC_W-2:0]   qmag;
  logic [31:0]        div_den, clip_abs;
  logic               div_neg;
  logic signed [NDC_W-1:0] ndc_next;

  logic signed [55:0] sx_prod, sy_prod;
  logic signed [63:0] x_full, y_full, z_full;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign addr      = {phase, k, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      view_left   <= '0;
      view_top    <= '0;
      view_width  <= 13'd640;
      view_height <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VIEW_LEFT:   view_left   <= cfg_data[11:0];
        CFG_VIEW_TOP:    view_top    <= cfg_data[11:0];
        CFG_VIEW_WIDTH:  view_width  <= cfg_data[12:0];
        CFG_VIEW_HEIGHT: view_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall && cmd.action == ACTION_LOAD) begin
      mem[cmd.coef_index] <= cmd.coef_value;
    end
    rdata <= mem[addr];
  end

  always_comb begin
    if (phase) begin
      mul_b = eye[k];
    end else begin
      unique case (k)
        2'd0:    mul_b = px;
        2'd1:    mul_b = py;
        2'd2:    mul_b = pz;
        default: mul_b = ONE;
      endcase
    end
  end

  ptsp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .en   (state == S_MUL),
    .a    (rdata),
    .b    (mul_b),
    .term (term)
  );

  assign acc_next = ((k == 2'd0) ? 64'sd0 : acc) + term;
  assign acc_sat  = sat32(acc_next);

  assign clip_abs  = clip[row][31] ? 32'(-clip[row]) : 32'(clip[row]);
  assign div_num   = {clip_abs, {FRAC_BITS{1'b0}}};
  assign div_den   = eye[2][31] ? 32'(-eye[2]) : 32'(eye[2]);
  assign div_start = (state == S_DIVGO);

  ptsp_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign div_neg  = clip[row][31] ^ ~eye[2][31];
  assign qmag     = (64'(div_quo) > NDC_MAX) ? (NDC_W-1)'(NDC_MAX)
                                             : (NDC_W-1)'(div_quo);
  assign ndc_next = div_neg ? -$signed({1'b0, qmag})
                            : $signed({1'b0, qmag});

  assign x_full = 64'(sx_prod >>> 1) + (64'(view_left) << FRAC_BITS);
  assign y_full = (64'(view_height) << FRAC_BITS)
                - (64'(sy_prod >>> 1) + (64'(view_top) << FRAC_BITS));
  assign z_full = (64'(ONE) + 64'(ndc[2])) >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      phase     <= 1'b0;
      row       <= '0;
      k         <= '0;
    end else begin
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.action == ACTION_PROJECT) begin
            px    <= cmd.point_x;
            py    <= cmd.point_y;
            pz    <= cmd.point_z;
            phase <= 1'b0;
            row   <= '0;
            k     <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          acc <= acc_next;
          if (k == 2'd3) begin
            k <= '0;
            if (!phase) begin
              eye[row] <= acc_sat;
              if (row == 2'd3) begin
                phase <= 1'b1;
                row   <= '0;
              end else begin
                row <= row + 1'b1;
              end
              state <= S_READ;
            end else begin
              clip[row[1:0] == 2'd3 ? 2'd2 : row] <= acc_sat;
              if (row == 2'd2) begin
                row    <= '0;
                zero_z <= (eye[2] == 32'sd0);
                state  <= (eye[2] == 32'sd0) ? S_OUT : S_DIVGO;
              end else begin
                row   <= row + 1'b1;
                state <= S_READ;
              end
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_READ;
          end
        end
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            ndc[row == 2'd3 ? 2'd2 : row] <= ndc_next;
            if (row == 2'd2) begin
              state <= S_MAP;
            end else begin
              row   <= row + 1'b1;
              state <= S_DIVGO;
            end
          end
        end
        S_MAP: begin
          sx_prod <= (ndc[0] + NDC_W'(ONE)) * $signed({1'b0, view_width});
          sy_prod <= (ndc[1] + NDC_W'(ONE)) * $signed({1'b0, view_height});
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            if (zero_z) begin
              res <= '0;
            end else begin
              res.projected_ok <= 1'b1;
              res.screen_x     <= sat32(x_full);
              res.screen_y     <= sat32(y_full);
              res.screen_depth <= sat32(z_full);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/ptsp_mac.sv
module ptsp_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] term
);
  logic signed [63:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      term <= prod >>> FRAC_BITS;
    end
  end
endmodule

// File: design/ptsp_div.sv
module ptsp_div #(
  parameter int NUM_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [31:0]      rem;
  logic [31:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [32:0]      shifted;
  logic             fit;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fit     = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        rem  <= fit ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
        quo  <= {quo[NUM_W-2:0], fit};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: tb/point_to_screen_projection_tb.sv
`timescale 1ns / 1ps

module point_to_screen_projection_tb;
  import ptsp_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint NDC_MAX = 64'sd1 << 40;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q = 32'hffff_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'ha5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int RAND_ITEMS = 1650;
  localparam int PHASES = 5;

  typedef struct {
    logic        act;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  point_to_screen_projection i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] coef_mem [COEF_COUNT];
  logic [11:0] vp_left = 12'd0;
  logic [11:0] vp_top = 12'd0;
  logic [12:0] vp_width = 13'd640;
  logic [12:0] vp_height = 13'd480;

  res_t screen_q [$];
  int errors = 0;
  int points_sent = 0;
  int loads_sent = 0;
  int results_seen = 0;
  int invalid_seen = 0;
  int items_sent = 0;
  int stall_pct = 0;
  int gap_on = 0;
  int hold_at = 900;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mulq(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  // applies one transaction to the predictor, returns 1 if it yields a result
  function automatic bit project_or_load(input cmd_t c, output res_t r);
    longint px, py, pz, d, q, sx, sy, sz;
    longint eye [4];
    longint clip [3];
    longint ndc [3];
    r = '0;
    if (c.action == ACTION_LOAD) begin
      coef_mem[c.coef_index] = c.coef_value;
      return 1'b0;
    end
    px = longint'(c.point_x);
    py = longint'(c.point_y);
    pz = longint'(c.point_z);
    for (int i = 0; i < 4; i++)
      eye[i] = clamp32(mulq(longint'(coef_mem[i]), px) + mulq(longint'(coef_mem[4+i]), py)
                       + mulq(longint'(coef_mem[8+i]), pz) + longint'(coef_mem[12+i]));
    for (int i = 0; i < 3; i++)
      clip[i] = clamp32(mulq(longint'(coef_mem[16+i]), eye[0])
                        + mulq(longint'(coef_mem[20+i]), eye[1])
                        + mulq(longint'(coef_mem[24+i]), eye[2])
                        + mulq(longint'(coef_mem[28+i]), eye[3]));
    if (eye[2] == 0) return 1'b1;
    d = -eye[2];
    for (int i = 0; i < 3; i++) begin
      q = (clip[i] * ONE) / d;
      if (q > NDC_MAX) q = NDC_MAX;
      if (q < -NDC_MAX) q = -NDC_MAX;
      ndc[i] = q;
    end
    sx = (((ndc[0] + ONE) * longint'(vp_width)) >>> 1) + longint'(vp_left) * ONE;
    sy = (((ndc[1] + ONE) * longint'(vp_height)) >>> 1) + longint'(vp_top) * ONE;
    sy = longint'(vp_height) * ONE - sy;
    sz = (ONE + ndc[2]) >>> 1;
    r.projected_ok = 1'b1;
    r.screen_x = 32'(clamp32(sx));
    r.screen_y = 32'(clamp32(sy));
    r.screen_depth = 32'(clamp32(sz));
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_on == 0 || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
    bit acc;
    res_t r;
    int gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = cmd_valid && !cmd_stall;
      @(posedge clk);
    end while (!acc);
    if (project_or_load(c, r)) begin
      screen_q.push_back(typed ? want : r);
      points_sent++;
    end else begin
      loads_sent++;
    end
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [31:0] val);
    cmd_t c;
    c = '0;
    c.action = ACTION_LOAD;
    c.coef_index = idx;
    c.coef_value = val;
    c.point_x = $urandom();
    c.point_y = $urandom();
    c.point_z = $urandom();
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    cmd_t c;
    c.action = ACTION_PROJECT;
    c.coef_index = 5'($urandom());
    c.coef_value = $urandom();
    c.point_x = x;
    c.point_y = y;
    c.point_z = z;
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    bit acc;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VIEW_LEFT:   vp_left = val[11:0];
      CFG_VIEW_TOP:    vp_top = val[11:0];
      CFG_VIEW_WIDTH:  vp_width = val[12:0];
      CFG_VIEW_HEIGHT: vp_height = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 30) return $urandom();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 99) < 30) return $urandom();
    return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
  endfunction

  // receiver stalls, with one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (!hold_done && items_sent >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // result checker
  always begin
    res_t got, want;
    @(negedge clk);
    if (!rst && res_valid && !res_stall) begin
      got = res;
      results_seen++;
      if (!got.projected_ok) invalid_seen++;
      if (screen_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = screen_q.pop_front();
        if (got.projected_ok !== want.projected_ok)
          report($sformatf("projected_ok got %b want %b", got.projected_ok,
                           want.projected_ok));
        if (got.screen_x !== want.screen_x)
          report($sformatf("screen_x got %h want %h", got.screen_x, want.screen_x));
        if (got.screen_y !== want.screen_y)
          report($sformatf("screen_y got %h want %h", got.screen_y, want.screen_y));
        if (got.screen_depth !== want.screen_depth)
          report($sformatf("screen_depth got %h want %h", got.screen_depth,
                           want.screen_depth));
      end
    end
  end

  always @(negedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("point_to_screen_projection_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t tab [14];
    int k;
    for (int i = 0; i < COEF_COUNT; i++) coef_mem[i] = '0;
    // identity modelview and projection, so the first rows read off directly
    tab[0]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h0, 32'h0, NEG_ONE_Q, 1'b1,
                '{1'b1, 32'd320 << 16, 32'd240 << 16, 32'h0}};
    tab[1]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '0};
    tab[2]  = '{ACTION_PROJECT, 5'd0, 32'h0, ONE_Q, ONE_Q, NEG_ONE_Q, 1'b1,
                '{1'b1, 32'd640 << 16, 32'h0, 32'h0}};
    tab[3]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h7fffffff, 32'h80000000, NEG_ONE_Q,
                1'b0, '0};
    tab[4]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                1'b0, '0};
    tab[5]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h0, 32'h0, 32'h80000000, 1'b0, '0};
    tab[6]  = '{ACTION_PROJECT, 5'd0, 32'h0, ONE_Q, NEG_ONE_Q, 32'h1, 1'b0, '0};
    tab[7]  = '{ACTION_LOAD, 5'd14, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, '0};
    tab[8]  = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0};
    tab[9]  = '{ACTION_LOAD, 5'd16, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0, '0};
    tab[10] = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h7fffffff, ONE_Q, ONE_Q, 1'b0, '0};
    tab[11] = '{ACTION_LOAD, 5'd12, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, '0};
    tab[12] = '{ACTION_PROJECT, 5'd0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000,
                1'b0, '0};
    tab[13] = '{ACTION_LOAD, 5'd31, 32'hffffffff, 32'h0, 32'h0, 32'h0, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < COEF_COUNT; i++)
      send_load(i[4:0], ((i % 16) % 5 == 0) ? ONE_Q : 32'h0);
    foreach (tab[i]) begin
      cmd_t c;
      c.action = tab[i].act;
      c.coef_index = tab[i].idx;
      c.coef_value = tab[i].val;
      c.point_x = tab[i].x;
      c.point_y = tab[i].y;
      c.point_z = tab[i].z;
      send_cmd(c, tab[i].typed, tab[i].want);
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          write_cfg(CFG_VIEW_LEFT, 32'h0);
          write_cfg(CFG_VIEW_TOP, 32'h0);
          write_cfg(CFG_VIEW_WIDTH, 32'h0);
          write_cfg(CFG_VIEW_HEIGHT, 32'h0);
        end
        2: begin
          write_cfg(CFG_VIEW_LEFT, 32'd4095);
          write_cfg(CFG_VIEW_TOP, 32'd4095);
          write_cfg(CFG_VIEW_WIDTH, 32'd4096);
          write_cfg(CFG_VIEW_HEIGHT, 32'd4096);
        end
        3: begin
          write_cfg(CFG_VIEW_LEFT, 32'hffffffff);
          write_cfg(CFG_VIEW_TOP, 32'hffffffff);
          write_cfg(CFG_VIEW_WIDTH, 32'hffffffff);
          write_cfg(CFG_VIEW_HEIGHT, 32'hffffffff);
          write_cfg(CFG_UNUSED, 32'h0);
        end
        4: begin
          write_cfg(CFG_VIEW_LEFT, $urandom_range(0, 4095));
          write_cfg(CFG_VIEW_TOP, $urandom_range(0, 4095));
          write_cfg(CFG_VIEW_WIDTH, $urandom_range(1, 4096));
          write_cfg(CFG_VIEW_HEIGHT, $urandom_range(1, 4096));
        end
        default: ;
      endcase
      stall_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
      gap_on = (ph != 0);
      k = 0;
      while (k < RAND_ITEMS / PHASES) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send_load(5'($urandom()), rand_coef());
          k++;
        end else if (r < 30) begin
          // zero the eye z coefficients, offset zero or -1, so the divide-by-zero path is sometimes exercised
          send_load(5'd2, 32'h0);
          send_load(5'd6, 32'h0);
          send_load(5'd10, 32'h0);
          send_load(5'd14, ($urandom_range(0, 1) == 0) ? 32'h0 : NEG_ONE_Q);
          send_point(rand_coord(), rand_coord(), rand_coord());
          k += 5;
        end else if (r < 33) begin
          send_load(5'd14, $urandom_range(0, 1) ? ONE_Q : NEG_ONE_Q);
          send_load(5'd10, NEG_ONE_Q);
          k += 2;
        end else begin
          send_point(rand_coord(), rand_coord(), rand_coord());
          k++;
        end
      end
      drain();
    end

    $display("covered %0d points (%0d flagged invalid) and %0d coefficient loads",
             points_sent, invalid_seen, loads_sent);
    $display("across %0d viewport settings, %0d results checked", PHASES, results_seen);
    if (errors == 0 && screen_q.size() == 0) begin
      $display("point_to_screen_projection_tb passed");
    end else begin
      $display("point_to_screen_projection_tb failed");
    end
    $finish;
  end

endmodule
